FILE: hdl/lwkr_pkg.sv
// Shared constants, types and sequencer states for the longest window block.
package lwkr_pkg;

   localparam int MAX_LEN = 4096;
   localparam int ALPHA   = 26;
   localparam int LEN_W   = 13;
   localparam int LTR_W   = 5;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int IDX_W   = $clog2(ALPHA);

   typedef logic [LEN_W-1:0] len_type;
   typedef logic [LTR_W-1:0] ltr_type;

   localparam len_type MAX_LEN_L = LEN_W'(MAX_LEN);
   localparam ltr_type ALPHA_L   = LTR_W'(ALPHA);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } st_type;

   typedef struct packed {
      logic    clear;
      logic    inc;
      logic    dec;
      ltr_type addr;
   } cnt_op_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      ltr_type           wdata;
      logic [ADDR_W-1:0] raddr;
   } hist_req_type;

   typedef struct packed {
      len_type best;
      len_type win;
      logic    ovf;
   } result_type;

endpackage

FILE: hdl/lwkr_hist_ram.sv
// Letter history memory: one write port, one registered read port.
module lwkr_hist_ram import lwkr_pkg::*; (
   input  logic         clock,
   input  hist_req_type req,
   output ltr_type      rd_data
);

   ltr_type hist_mem [MAX_LEN];
   ltr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         hist_mem[req.waddr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lwkr_counts.sv
// Per-letter window counters with one shared read, increment and decrement port.
module lwkr_counts import lwkr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cnt_op_type op,
   output len_type    rd_count
);

   len_type cnt_ff [ALPHA];
   len_type cnt_in;
   logic    in_range;

   assign in_range = (op.addr < ALPHA_L);

   always_comb begin
      rd_count = '0;
      if (in_range) begin
         rd_count = cnt_ff[op.addr[IDX_W-1:0]];
      end
   end

   always_comb begin
      cnt_in = rd_count;
      if (op.inc) begin
         cnt_in = rd_count + len_type'(1);
      end else if (op.dec && (rd_count != '0)) begin
         cnt_in = rd_count - len_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || op.clear) begin
         for (int i = 0; i < ALPHA; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if ((op.inc || op.dec) && in_range) begin
         cnt_ff[op.addr[IDX_W-1:0]] <= cnt_in;
      end
   end

endmodule

FILE: hdl/lwkr_seq.sv
// Sequencer and window datapath: add, shrink check, left-end removal, count scan.
module lwkr_seq import lwkr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  ltr_type      req_letter,
   input  logic         req_first,
   output logic         req_ready,
   input  len_type      max_rep,
   output hist_req_type hist_req,
   input  ltr_type      hist_rd,
   output cnt_op_type   cnt_op,
   input  len_type      rd_count,
   input  logic         out_free,
   output logic         res_load,
   output result_type   res
);

   st_type            state_ff, state_in;
   ltr_type           letter_ff, letter_in;
   len_type           start_ff, start_in;
   len_type           pos_ff, pos_in;
   len_type           best_ff, best_in;
   logic              ovf_ff, ovf_in;
   len_type           max_ff, max_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   len_type           acc_ff, acc_in;

   len_type           win;
   len_type           cnt_plus;
   len_type           scan_max;
   logic              shrink;
   logic              accept;
   logic              skip_letter;
   logic              full;

   assign win         = pos_ff - start_ff;
   assign cnt_plus    = rd_count + len_type'(1);
   assign scan_max    = (rd_count > acc_ff) ? rd_count : acc_ff;
   assign shrink      = ({1'b0, win} > ({1'b0, max_ff} + {1'b0, max_rep}))
                        && (start_ff != pos_ff);
   assign accept      = req_valid && req_ready;
   assign skip_letter = (letter_ff >= ALPHA_L);
   assign full        = (pos_ff == MAX_LEN_L);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = (skip_letter || full) ? ST_DONE : ST_CHECK;
         end
         ST_CHECK: begin
            state_in = shrink ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = (rd_count == max_ff) ? ST_SCAN : ST_CHECK;
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      res_load       = 1'b0;
      cnt_op         = '0;
      cnt_op.addr    = letter_ff;
      hist_req       = '0;
      hist_req.waddr = pos_ff[ADDR_W-1:0];
      hist_req.wdata = letter_ff;
      hist_req.raddr = start_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cnt_op.clear = req_valid && req_first;
         end
         ST_ADD: begin
            cnt_op.inc  = !(skip_letter || full);
            hist_req.we = !(skip_letter || full);
         end
         ST_READ: begin
            cnt_op.addr = hist_rd;
            cnt_op.dec  = 1'b1;
         end
         ST_SCAN: begin
            cnt_op.addr = LTR_W'(idx_ff);
         end
         ST_DONE: begin
            res_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      letter_in = letter_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      best_in   = best_ff;
      ovf_in    = ovf_ff;
      max_in    = max_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               letter_in = req_letter;
               if (req_first) begin
                  start_in = '0;
                  pos_in   = '0;
                  best_in  = '0;
                  ovf_in   = 1'b0;
                  max_in   = '0;
               end
            end
         end
         ST_ADD: begin
            if (!skip_letter) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  pos_in = pos_ff + len_type'(1);
                  if (cnt_plus > max_ff) max_in = cnt_plus;
               end
            end
         end
         ST_CHECK: begin
            if (!shrink && (win > best_ff)) best_in = win;
         end
         ST_READ: begin
            start_in = start_ff + len_type'(1);
            idx_in   = '0;
            acc_in   = '0;
         end
         ST_SCAN: begin
            acc_in = scan_max;
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) max_in = scan_max;
         end
         ST_DONE: begin
            letter_in = letter_ff;
         end
         default: begin
            letter_in = letter_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         best_ff  <= '0;
         ovf_ff   <= 1'b0;
         max_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         best_ff  <= best_in;
         ovf_ff   <= ovf_in;
         max_ff   <= max_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      acc_ff    <= acc_in;
   end

   assign res.best = best_ff;
   assign res.win  = win;
   assign res.ovf  = ovf_ff;

endmodule

FILE: hdl/longest_window_k_replacements_top.sv
// Top level of the longest window with k replacements block.
// Takes one upper-case letter per word (tuser marks the first letter of a new
// string) and returns one word per letter with the best window length so far,
// the current window length and an overflow flag. A letter with no removal
// passes the add, check and done states, a letter outside the alphabet or past
// the full string length only add and done. Each letter dropped from the left
// end adds a read state and another check (history memory read then counter
// decrement), and a drop that hits the highest count adds a rescan of the
// letter counters through the one shared compare. The done state of a letter
// holds while the output register still holds an untaken word. The result sits
// in an output register, so a new letter is taken while the previous word still
// waits. The user is to write max_replacements through the csr port only while
// the block is idle; the block itself does not enforce this.
module longest_window_k_replacements_top import lwkr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter
   input  logic        req_tuser,   // [0] first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [12:0] best_length, [25:13] window_length,
                                    // [26] overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data     // [12:0] max_replacements
);

   len_type      max_rep_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff;
   hist_req_type hist_req;
   ltr_type      hist_rd;
   cnt_op_type   cnt_op;
   len_type      rd_count;
   logic         out_free;
   logic         res_load;
   result_type   res;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   lwkr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_letter (req_tdata[LTR_W-1:0]),
      .req_first  (req_tuser),
      .req_ready  (req_tready),
      .max_rep    (max_rep_ff),
      .hist_req   (hist_req),
      .hist_rd    (hist_rd),
      .cnt_op     (cnt_op),
      .rd_count   (rd_count),
      .out_free   (out_free),
      .res_load   (res_load),
      .res        (res)
   );

   lwkr_hist_ram u_hist (
      .clock   (clock),
      .req     (hist_req),
      .rd_data (hist_rd)
   );

   lwkr_counts u_counts (
      .clock    (clock),
      .reset    (reset),
      .op       (cnt_op),
      .rd_count (rd_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_rep_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_rep_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.ovf, rsp_data_ff.win, rsp_data_ff.best};

endmodule

FILE: hdl/lwkr_checker.sv
// Port-level checks for the longest window block, bound to the top level.
module lwkr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // hold a stalled word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // advance one letter at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("letter accepted while previous letter in work");

   // window never exceeds best length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25:13] <= rsp_tdata[12:0]))
      else $error("window length above best length");

   // padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:27] == 5'b0))
      else $error("response padding not zero");

endmodule

bind longest_window_k_replacements_top lwkr_checker u_lwkr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/longest_window_k_replacements_top_tb.sv
// Self-checking testbench for the longest window with k replacements block.
`timescale 1ns / 100ps

import lwkr_pkg::*;

class window_scoreboard;
   len_type    limit;
   len_type    counts [ALPHA];
   ltr_type    history [MAX_LEN];
   len_type    wstart;
   len_type    npos;
   len_type    best;
   logic       ovf;
   result_type pending_q [$];
   int         errors;

   function new();
      limit  = '0;
      errors = 0;
      clear_string();
   endfunction

   function void clear_string();
      foreach (counts[i]) counts[i] = '0;
      wstart = '0;
      npos   = '0;
      best   = '0;
      ovf    = 1'b0;
   endfunction

   function len_type peak_count();
      len_type peak;
      peak = '0;
      foreach (counts[i]) begin
         if (counts[i] > peak) peak = counts[i];
      end
      return peak;
   endfunction

   function void note_letter(ltr_type letter, logic first_flag);
      len_type    win;
      ltr_type    old;
      result_type exp_word;
      if (first_flag) clear_string();
      if (letter < ALPHA_L) begin
         if (npos >= MAX_LEN_L) begin
            ovf = 1'b1;
         end else begin
            history[npos[ADDR_W-1:0]] = letter;
            counts[letter] = counts[letter] + 1'b1;
            npos = npos + 1'b1;
            win  = npos - wstart;
            // drop from the left end until the window fits the limit
            while ((win - peak_count()) > limit && wstart < npos) begin
               old = history[wstart[ADDR_W-1:0]];
               if (old < ALPHA_L && counts[old] > 0) counts[old] = counts[old] - 1'b1;
               wstart = wstart + 1'b1;
               win    = npos - wstart;
            end
            if (win > best) best = win;
         end
      end
      exp_word.best = best;
      exp_word.win  = npos - wstart;
      exp_word.ovf  = ovf;
      pending_q = {pending_q, exp_word};
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task check_word(logic [31:0] data);
      result_type exp_word;
      if (pending_q.size() == 0) begin
         report($sformatf("result word 0x%08h with no letter waiting", data));
         return;
      end
      exp_word = pending_q.pop_front();
      if (data[12:0] !== exp_word.best)
         report($sformatf("best_length got %0d want %0d", data[12:0], exp_word.best));
      if (data[25:13] !== exp_word.win)
         report($sformatf("window_length got %0d want %0d", data[25:13], exp_word.win));
      if (data[26] !== exp_word.ovf)
         report($sformatf("overflow got %0b want %0b", data[26], exp_word.ovf));
   endtask
endclass

module longest_window_k_replacements_top_tb;

   localparam int      CYCLE_LIMIT  = 1_000_000;
   localparam int      DRAIN_CYCLES = 64;
   localparam ltr_type LTR_A        = 5'd0;
   localparam ltr_type LTR_B        = 5'd1;
   localparam ltr_type LTR_Z        = 5'd25;
   localparam ltr_type LTR_OUT      = 5'd26;
   localparam ltr_type LTR_MAX      = 5'd31;
   localparam len_type LIMIT_MAX    = 13'h1FFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [12:0] csr_data;

   window_scoreboard sb;
   int unsigned      cycles = 0;
   bit               quiet = 1'b0;

   longest_window_k_replacements_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [4:0] letter
      .req_tuser  (req_tuser),   // [0] first
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [12:0] best_length, [25:13] window_length, [26] overflow
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // [12:0] max_replacements
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("longest_window_k_replacements_top_tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
   end

   task send_letter(input ltr_type letter, input logic first_flag);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, letter};
      req_tuser  <= first_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_letter(letter, first_flag);
   endtask

   task write_limit(input len_type value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b1;
      csr_data   <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task send_string(input int length, input int spread);
      ltr_type base;
      ltr_type letter;
      logic    first_flag;
      int      r;
      base = ltr_type'($urandom_range(25));
      for (int i = 0; i < length; i++) begin
         r = $urandom_range(99);
         if (r < 6) letter = ltr_type'($urandom_range(31, 26));
         else if (r < 12) letter = ltr_type'($urandom_range(25));
         else letter = ltr_type'((base + $urandom_range(spread - 1)) % ALPHA);
         if (i == 0) first_flag = ($urandom_range(99) < 90);
         else first_flag = ($urandom_range(99) < 2);
         send_letter(letter, first_flag);
      end
   endtask

   task run_phase(input len_type k, input int items);
      int n;
      int len;
      int r;
      write_limit(k);
      n = 0;
      while (n < items) begin
         r = $urandom_range(99);
         if (r < 80) len = $urandom_range(12, 1);
         else if (r < 95) len = $urandom_range(40, 13);
         else len = $urandom_range(120, 41);
         if ($urandom_range(99) < 85) send_string(len, $urandom_range(4, 1));
         else send_string(len, ALPHA);
         n += len;
      end
   endtask

   initial begin
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limit at its reset value of zero
      send_letter(LTR_MAX, 1'b1);
      send_letter(LTR_A, 1'b0);
      send_letter(LTR_A, 1'b0);
      send_letter(LTR_Z, 1'b0);
      send_letter(LTR_OUT, 1'b0);
      send_letter(LTR_Z, 1'b0);
      send_letter(LTR_B, 1'b1);
      send_letter(LTR_MAX, 1'b1);

      write_limit(13'd1);
      send_letter(LTR_A, 1'b1);
      send_letter(LTR_A, 1'b0);
      send_letter(LTR_B, 1'b0);
      send_letter(LTR_A, 1'b0);
      send_letter(LTR_B, 1'b0);
      send_letter(LTR_B, 1'b0);
      send_letter(LTR_A, 1'b0);

      write_limit(LIMIT_MAX);
      send_letter(LTR_Z, 1'b1);
      send_letter(LTR_A, 1'b0);
      send_letter(LTR_MAX, 1'b0);
      send_letter(LTR_B, 1'b0);

      // run one string past its full length, then start afresh
      send_letter(LTR_A, 1'b1);
      for (int i = 1; i < MAX_LEN + 4; i++) send_letter(ltr_type'($urandom_range(25)), 1'b0);
      send_letter(LTR_MAX, 1'b0);
      send_letter(LTR_Z, 1'b1);
      send_letter(LTR_Z, 1'b0);

      run_phase(13'd1, 88);
      run_phase(13'd2, 88);
      quiet = 1'b1;
      run_phase(13'd3, 88);
      quiet = 1'b0;
      run_phase(13'd4096, 88);
      run_phase(LIMIT_MAX, 88);
      run_phase(len_type'($urandom_range(15)), 88);
      run_phase(13'd0, 88);
      run_phase(len_type'($urandom_range(8191)), 88);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("longest_window_k_replacements_top_tb: PASS");
      end else begin
         $display("longest_window_k_replacements_top_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/lwkr_pkg.sv
hdl/lwkr_hist_ram.sv
hdl/lwkr_counts.sv
hdl/lwkr_seq.sv
hdl/longest_window_k_replacements_top.sv
hdl/lwkr_checker.sv
tb/longest_window_k_replacements_top_tb.sv
